FILE: rtl/core/fot_pkg.sv
// Shared types and constants for the frame orientation transform.
package fot_pkg;

    // Default frame store geometry
    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    // Frame size after reset, before clamping to the store geometry
    localparam int RESET_WIDTH  = 8;
    localparam int RESET_HEIGHT = 6;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;

    localparam logic [CFG_INDEX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT = 2'd2;

    // Item actions
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // Transform modes
    localparam int MODE_W = 3;

    localparam logic [MODE_W-1:0] MODE_HFLIP  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_VFLIP  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ROT90  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ROT180 = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ROT270 = 3'd4;
    localparam logic [MODE_W-1:0] MODE_INVERT = 3'd5;

    // Pixel width and invert characters
    localparam int PIX_W = 8;

    localparam logic [PIX_W-1:0] CHAR_STAR = 8'h2A;
    localparam logic [PIX_W-1:0] CHAR_DASH = 8'h2D;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ADDR,
        ST_FETCH,
        ST_EMIT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic load;
        logic addr;
        logic fetch;
        logic emit;
    } cmd_t;

endpackage

FILE: rtl/core/fot_ram.sv
// Generic single-port RAM with registered read data.
module fot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/fot_ctrl.sv
// Controller state machine for the frame orientation transform.
module fot_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          action,
    output logic          busy,
    output fot_pkg::cmd_t cmd
);

    fot_pkg::state_t state_reg;
    fot_pkg::state_t state_next;

    // Hold the current state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fot_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance through load or read steps and issue commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            fot_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = (action == fot_pkg::ACT_READ) ?
                                 fot_pkg::ST_ADDR : fot_pkg::ST_LOAD;
                end
            end
            fot_pkg::ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = fot_pkg::ST_IDLE;
            end
            fot_pkg::ST_ADDR:
            begin
                cmd.addr   = 1'b1;
                state_next = fot_pkg::ST_FETCH;
            end
            fot_pkg::ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = fot_pkg::ST_EMIT;
            end
            fot_pkg::ST_EMIT:
            begin
                cmd.emit   = 1'b1;
                state_next = fot_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = fot_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/fot_datapath.sv
// Datapath: configuration, position counters, address mapping and frame store.
module fot_datapath #(
    parameter int MAX_WIDTH  = fot_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = fot_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  fot_pkg::cmd_t                    cmd,
    input  logic [fot_pkg::PIX_W-1:0]        pixel_in,
    input  logic                             cfg_write,
    input  logic [fot_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [fot_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                             result_valid,
    output logic [fot_pkg::PIX_W-1:0]        pixel_out,
    output logic                             frame_last
);

    localparam int MAXD    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int PW      = $clog2(MAXD);
    localparam int SW      = PW + 1;
    localparam int CMPW    = (SW > fot_pkg::CFG_DATA_W) ? SW : fot_pkg::CFG_DATA_W;
    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW      = $clog2(DEPTH);
    localparam int RESET_W = (fot_pkg::RESET_WIDTH > MAX_WIDTH) ?
                             MAX_WIDTH : fot_pkg::RESET_WIDTH;
    localparam int RESET_H = (fot_pkg::RESET_HEIGHT > MAX_HEIGHT) ?
                             MAX_HEIGHT : fot_pkg::RESET_HEIGHT;

    // Clamp a written size into 1..maximum
    function automatic logic [SW-1:0] clamp_size(
        input logic [fot_pkg::CFG_DATA_W-1:0] v,
        input logic [CMPW-1:0]                maxv
    );
        logic [CMPW-1:0] ve;
        begin
            ve = CMPW'(v);
            if (v == '0)
            begin
                return SW'(1);
            end
            if (ve > maxv)
            begin
                return SW'(maxv);
            end
            return SW'(ve);
        end
    endfunction

    logic [fot_pkg::MODE_W-1:0] mode_reg;
    logic [SW-1:0]              width_reg;
    logic [SW-1:0]              height_reg;
    logic [PW-1:0]              load_row_reg, load_row_next;
    logic [PW-1:0]              load_col_reg, load_col_next;
    logic [PW-1:0]              read_row_reg, read_row_next;
    logic [PW-1:0]              read_col_reg, read_col_next;
    logic [fot_pkg::PIX_W-1:0]  pixel_reg;
    logic [PW-1:0]              src_row_reg, src_row_next;
    logic [PW-1:0]              src_col_reg, src_col_next;
    logic                       last_reg, last_next;
    logic                       valid_reg;
    logic [fot_pkg::PIX_W-1:0]  pixel_out_reg, pixel_out_next;
    logic                       frame_last_reg;

    logic                       load_wrap;
    logic [PW-1:0]              lr, lc;
    logic [SW-1:0]              lc_inc, lr_inc;
    logic                       rotated;
    logic [SW-1:0]              out_w, out_h;
    logic                       read_wrap;
    logic [PW-1:0]              rr, rc;
    logic [SW-1:0]              rc_inc, rr_inc;
    logic [SW-1:0]              w_m1, h_m1;
    logic [PW-1:0]              row_sel, col_sel;
    logic [AW-1:0]              ram_addr;
    logic [fot_pkg::PIX_W-1:0]  ram_rdata;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= fot_pkg::MODE_HFLIP;
            width_reg  <= SW'(RESET_W);
            height_reg <= SW'(RESET_H);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                fot_pkg::CFG_MODE:
                begin
                    mode_reg <= cfg_data[fot_pkg::MODE_W-1:0];
                end
                fot_pkg::CFG_WIDTH:
                begin
                    width_reg <= clamp_size(cfg_data, CMPW'(MAX_WIDTH));
                end
                fot_pkg::CFG_HEIGHT:
                begin
                    height_reg <= clamp_size(cfg_data, CMPW'(MAX_HEIGHT));
                end
                default:
                begin
                end
            endcase
        end
    end

    // Restart the load position when it lies outside the frame
    assign load_wrap = ({1'b0, load_row_reg} >= height_reg) ||
                       ({1'b0, load_col_reg} >= width_reg);
    assign lr        = load_wrap ? '0 : load_row_reg;
    assign lc        = load_wrap ? '0 : load_col_reg;
    assign lc_inc    = {1'b0, lc} + SW'(1);
    assign lr_inc    = {1'b0, lr} + SW'(1);

    // Output frame geometry and read position
    assign rotated   = (mode_reg == fot_pkg::MODE_ROT90) ||
                       (mode_reg == fot_pkg::MODE_ROT270);
    assign out_w     = rotated ? height_reg : width_reg;
    assign out_h     = rotated ? width_reg : height_reg;
    assign read_wrap = ({1'b0, read_row_reg} >= out_h) ||
                       ({1'b0, read_col_reg} >= out_w);
    assign rr        = read_wrap ? '0 : read_row_reg;
    assign rc        = read_wrap ? '0 : read_col_reg;
    assign rc_inc    = {1'b0, rc} + SW'(1);
    assign rr_inc    = {1'b0, rr} + SW'(1);
    assign w_m1      = width_reg - SW'(1);
    assign h_m1      = height_reg - SW'(1);

    // Advance the position counters and map output to source position
    always_comb
    begin
        load_row_next = load_row_reg;
        load_col_next = load_col_reg;
        read_row_next = read_row_reg;
        read_col_next = read_col_reg;
        src_row_next  = src_row_reg;
        src_col_next  = src_col_reg;
        last_next     = last_reg;
        if (cmd.load)
        begin
            if (lc_inc >= width_reg)
            begin
                load_col_next = '0;
                load_row_next = (lr_inc >= height_reg) ? '0 : lr_inc[PW-1:0];
            end
            else
            begin
                load_col_next = lc_inc[PW-1:0];
                load_row_next = lr;
            end
            if (lr == '0 && lc == '0)
            begin
                read_row_next = '0;
                read_col_next = '0;
            end
        end
        if (cmd.addr)
        begin
            case (mode_reg)
                fot_pkg::MODE_HFLIP:
                begin
                    src_row_next = rr;
                    src_col_next = PW'(w_m1 - {1'b0, rc});
                end
                fot_pkg::MODE_VFLIP:
                begin
                    src_row_next = PW'(h_m1 - {1'b0, rr});
                    src_col_next = rc;
                end
                fot_pkg::MODE_ROT90:
                begin
                    src_row_next = PW'(h_m1 - {1'b0, rc});
                    src_col_next = rr;
                end
                fot_pkg::MODE_ROT180:
                begin
                    src_row_next = PW'(h_m1 - {1'b0, rr});
                    src_col_next = PW'(w_m1 - {1'b0, rc});
                end
                fot_pkg::MODE_ROT270:
                begin
                    src_row_next = rc;
                    src_col_next = PW'(w_m1 - {1'b0, rr});
                end
                default:
                begin
                    src_row_next = rr;
                    src_col_next = rc;
                end
            endcase
            last_next = (rr_inc == out_h) && (rc_inc == out_w);
            if (rc_inc >= out_w)
            begin
                read_col_next = '0;
                read_row_next = (rr_inc >= out_h) ? '0 : rr_inc[PW-1:0];
            end
            else
            begin
                read_col_next = rc_inc[PW-1:0];
                read_row_next = rr;
            end
        end
    end

    // Hold position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_row_reg <= '0;
            load_col_reg <= '0;
            read_row_reg <= '0;
            read_col_reg <= '0;
        end
        else
        begin
            load_row_reg <= load_row_next;
            load_col_reg <= load_col_next;
            read_row_reg <= read_row_next;
            read_col_reg <= read_col_next;
        end
    end

    // Hold item payload and mapped source position
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pixel_reg <= pixel_in;
        end
        src_row_reg <= src_row_next;
        src_col_reg <= src_col_next;
        last_reg    <= last_next;
    end

    // Form the store address from a row and column
    assign row_sel  = cmd.load ? lr : src_row_reg;
    assign col_sel  = cmd.load ? lc : src_col_reg;
    assign ram_addr = AW'(row_sel) * AW'(MAX_WIDTH) + AW'(col_sel);

    fot_ram #(
        .WIDTH (fot_pkg::PIX_W),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .clk   (clk),
        .we    (cmd.load),
        .re    (cmd.fetch),
        .addr  (ram_addr),
        .wdata (pixel_reg),
        .rdata (ram_rdata)
    );

    // Apply the invert mapping to the fetched pixel
    always_comb
    begin
        pixel_out_next = ram_rdata;
        if (mode_reg == fot_pkg::MODE_INVERT)
        begin
            pixel_out_next = (ram_rdata == fot_pkg::CHAR_STAR) ?
                             fot_pkg::CHAR_DASH : fot_pkg::CHAR_STAR;
        end
    end

    // Drive the result strobe for one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.emit;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            pixel_out_reg  <= pixel_out_next;
            frame_last_reg <= last_reg;
        end
    end

    assign result_valid = valid_reg;
    assign pixel_out    = pixel_out_reg;
    assign frame_last   = frame_last_reg;

endmodule

FILE: rtl/core/frame_orientation_transform.sv
// Top level of the frame orientation transform: flips, rotations and invert.
//
//  channel   handshake                      payload
//  -------   ----------------------------   --------------------------
//  item      start & !busy                  action, pixel_in
//  result    result_valid, one cycle        pixel_out, frame_last
//  config    cfg_valid & cfg_ready          cfg_index, cfg_data
//
// A load is accepted, then written into the frame store.
// A read steps through accept, source address mapping, store read, then
// invert into the output register, registered together with the strobe.
// The strobe cycle overlaps the next accept. Reset clears counters and
// configuration; the frame store holds no reset. Results are never stalled.
module frame_orientation_transform #(
    parameter int MAX_WIDTH  = fot_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = fot_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             action,
    input  logic [fot_pkg::PIX_W-1:0]        pixel_in,
    output logic                             result_valid,
    output logic [fot_pkg::PIX_W-1:0]        pixel_out,
    output logic                             frame_last,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fot_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [fot_pkg::CFG_DATA_W-1:0]   cfg_data
);

    fot_pkg::cmd_t cmd;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    fot_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .busy   (busy),
        .cmd    (cmd)
    );

    fot_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .pixel_in     (pixel_in),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .pixel_out    (pixel_out),
        .frame_last   (frame_last)
    );

endmodule
